// ===== rtl/lfpd_pkg.sv =====
// Shared types and constants for the line follower PD steering unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package lfpd_pkg;

   localparam int HISTORY_DEPTH_DEFAULT  = 20;
   localparam int INTEGRAL_LIMIT_DEFAULT = 1000;
   localparam int POSITION_BITS_DEFAULT  = 8;

   localparam int GAIN_BITS     = 24;
   localparam int SPEED_BITS    = 8;
   localparam int DRIVE_BITS    = 9;
   localparam int Q_BITS        = 16;
   localparam int STEER_LIMIT   = 20;
   localparam int STRAIGHT_BAND = 8;
   localparam int DRIVE_MAX     = 255;
   localparam int TAP_TEST      = 3;
   localparam int TAP_RACE      = 8;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0]  GAIN_PROP_RESET  = 24'd131072;
   localparam logic [GAIN_BITS-1:0]  GAIN_DERIV_RESET = 24'd471859;
   localparam logic [GAIN_BITS-1:0]  GAIN_INTEG_RESET = 24'd33;
   localparam logic [SPEED_BITS-1:0] BASE_SPEED_RESET = 8'd75;

   typedef enum logic [2:0] {
      REG_GAIN_PROP  = 3'd0,
      REG_GAIN_DERIV = 3'd1,
      REG_GAIN_INTEG = 3'd2,
      REG_BASE_SPEED = 3'd3,
      REG_RUN_MODE   = 3'd4
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_P  = 6'b000010,
      ST_MUL_D  = 6'b000100,
      ST_MUL_I  = 6'b001000,
      ST_ACC_I  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_p;
      logic mul_d;
      logic mul_i;
      logic acc_i;
      logic out_load;
   } cmd_type;

endpackage

// ===== rtl/lfpd_ctrl.sv =====
// Sequencing state machine for the steering unit: handshakes and step commands.
// Depends on lfpd_pkg.
module lfpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output lfpd_pkg::cmd_type cmd
);

   lfpd_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == lfpd_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.accept   = req_tready && req_tvalid;
      cmd.mul_p    = (state_ff == lfpd_pkg::ST_MUL_P);
      cmd.mul_d    = (state_ff == lfpd_pkg::ST_MUL_D);
      cmd.mul_i    = (state_ff == lfpd_pkg::ST_MUL_I);
      cmd.acc_i    = (state_ff == lfpd_pkg::ST_ACC_I);
      cmd.out_load = (state_ff == lfpd_pkg::ST_FINISH) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfpd_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lfpd_pkg::ST_MUL_P;
         end
         lfpd_pkg::ST_MUL_P:  state_in = lfpd_pkg::ST_MUL_D;
         lfpd_pkg::ST_MUL_D:  state_in = lfpd_pkg::ST_MUL_I;
         lfpd_pkg::ST_MUL_I:  state_in = lfpd_pkg::ST_ACC_I;
         lfpd_pkg::ST_ACC_I:  state_in = lfpd_pkg::ST_FINISH;
         lfpd_pkg::ST_FINISH: begin
            if (out_free) state_in = lfpd_pkg::ST_IDLE;
         end
         default: state_in = lfpd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfpd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while a result is still pending");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == lfpd_pkg::ST_MUL_P))
      else $error("accepted item did not start the multiply sequence");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.mul_p, cmd.mul_d, cmd.mul_i, cmd.acc_i, cmd.out_load}))
      else $error("more than one datapath step commanded");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfpd_pkg::ST_FINISH) && !out_free |=> (state_ff == lfpd_pkg::ST_FINISH))
      else $error("finished item left before the result register was free");

endmodule

// ===== rtl/lfpd_datapath.sv =====
// Datapath of the steering unit: position history, integral, shared multiplier,
// accumulator and drive conversion. Depends on lfpd_pkg.
module lfpd_datapath #(
   parameter int HISTORY_DEPTH  = lfpd_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int INTEGRAL_LIMIT = lfpd_pkg::INTEGRAL_LIMIT_DEFAULT,
   parameter int POSITION_BITS  = lfpd_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfpd_pkg::cmd_type                    cmd,
   input  logic [lfpd_pkg::GAIN_BITS-1:0]       gain_prop,
   input  logic [lfpd_pkg::GAIN_BITS-1:0]       gain_deriv,
   input  logic [lfpd_pkg::GAIN_BITS-1:0]       gain_integ,
   input  logic [lfpd_pkg::SPEED_BITS-1:0]      base_speed,
   input  logic                                 run_mode,
   input  logic [POSITION_BITS-1:0]             position,
   input  logic                                 restart,
   output logic signed [lfpd_pkg::DRIVE_BITS-1:0] left_drive,
   output logic signed [lfpd_pkg::DRIVE_BITS-1:0] right_drive,
   output logic                                 straight,
   output logic                                 steer_positive
);

   localparam int ES_W   = $clog2(INTEGRAL_LIMIT + 2**(POSITION_BITS-1) + 1) + 1;
   localparam int DIFF_W = POSITION_BITS + 1;
   localparam int OP_W   = (DIFF_W > ES_W) ? DIFF_W : ES_W;
   localparam int GS_W   = lfpd_pkg::GAIN_BITS + 1;
   localparam int PROD_W = GS_W + OP_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int QW     = ACC_W + 1 - lfpd_pkg::Q_BITS;
   localparam int QB     = lfpd_pkg::Q_BITS;
   localparam int DW     = lfpd_pkg::DRIVE_BITS;

   localparam logic signed [ES_W-1:0]  LIM_POS  = ES_W'(INTEGRAL_LIMIT);
   localparam logic signed [ES_W-1:0]  LIM_NEG  = -LIM_POS;
   localparam logic signed [ACC_W-1:0] STEER_HI = ACC_W'(lfpd_pkg::STEER_LIMIT) <<< QB;
   localparam logic signed [ACC_W-1:0] STEER_LO = -STEER_HI;
   localparam logic signed [QW-1:0]    DMAX     = QW'(lfpd_pkg::DRIVE_MAX);
   localparam logic signed [QW-1:0]    DMIN     = -DMAX;
   localparam logic signed [15:0]      BAND_HI  = 16'(lfpd_pkg::STRAIGHT_BAND);
   localparam logic signed [15:0]      BAND_LO  = -BAND_HI;

   logic signed [POSITION_BITS-1:0] hist_ff [HISTORY_DEPTH];
   logic signed [POSITION_BITS-1:0] hist_in [HISTORY_DEPTH];
   logic signed [ES_W-1:0]          es_ff, es_in, es_base, es_zero;
   logic signed [POSITION_BITS-1:0] pos_in, pos_ff;
   logic                            straight_ff, straight_in;
   logic signed [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [GS_W-1:0]          mul_gain;
   logic signed [OP_W-1:0]          mul_data;
   logic signed [DIFF_W-1:0]        diff;
   logic signed [POSITION_BITS-1:0] tap;
   logic signed [ACC_W-1:0]         integ_term, steer_clamped;
   logic signed [ACC_W:0]           steer_ext, slow_speed, acc_mag;
   logic signed [DW-1:0]            left_in, right_in, slow_drive, base_drive;
   logic                            positive_in;
   logic signed [DW-1:0]            left_ff, right_ff;
   logic                            straight_out_ff, positive_ff;

   function automatic logic signed [DW-1:0] trunc_sat(input logic signed [ACC_W:0] v);
      logic signed [QW-1:0] q;
      q = v[ACC_W:QB];
      if (v[ACC_W] && (v[QB-1:0] != '0)) q = q + QW'(1);
      if (q > DMAX) q = DMAX;
      else if (q < DMIN) q = DMIN;
      return q[DW-1:0];
   endfunction

   assign pos_in = position;

   always_comb begin
      hist_in[0] = pos_in;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = restart ? '0 : hist_ff[i-1];
      end
      straight_in = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if ((16'(hist_in[i]) > BAND_HI) || (16'(hist_in[i]) < BAND_LO)) straight_in = 1'b0;
      end
   end

   always_comb begin
      es_base = restart ? '0 : es_ff;
      es_zero = (pos_in == '0) ? '0 : es_base;
      es_in   = es_base;
      if (!run_mode) begin
         if (es_zero >= LIM_POS) es_in = LIM_POS;
         else if (es_zero <= LIM_NEG) es_in = LIM_NEG;
         else es_in = es_zero + ES_W'(pos_in);
      end
   end

   assign tap  = run_mode ? hist_ff[lfpd_pkg::TAP_RACE] : hist_ff[lfpd_pkg::TAP_TEST];
   assign diff = DIFF_W'(pos_ff) - DIFF_W'(tap);

   always_comb begin
      mul_gain = $signed({1'b0, gain_prop});
      mul_data = OP_W'(pos_ff);
      if (cmd.mul_d) begin
         mul_gain = $signed({1'b0, gain_deriv});
         mul_data = OP_W'(diff);
      end else if (cmd.mul_i) begin
         mul_gain = run_mode ? '0 : $signed({1'b0, gain_integ});
         mul_data = OP_W'(es_ff);
      end
   end

   assign prod_in = mul_gain * mul_data;

   always_comb begin
      integ_term = ACC_W'($signed({prod_ff[PROD_W-1:QB], {QB{1'b0}}}));
      if (prod_ff[PROD_W-1] && (prod_ff[QB-1:0] != '0)) begin
         integ_term = integ_term + (ACC_W'(1) <<< QB);
      end
      acc_in = acc_ff;
      if (cmd.mul_d) acc_in = ACC_W'(prod_ff);
      else if (cmd.mul_i) acc_in = acc_ff + ACC_W'(prod_ff);
      else if (cmd.acc_i) acc_in = acc_ff + integ_term;
   end

   always_comb begin
      steer_clamped = acc_ff;
      if (acc_ff > STEER_HI) steer_clamped = STEER_HI;
      else if (acc_ff < STEER_LO) steer_clamped = STEER_LO;
      steer_ext  = (ACC_W+1)'(steer_clamped);
      acc_mag    = acc_ff[ACC_W-1] ? -(ACC_W+1)'(acc_ff) : (ACC_W+1)'(acc_ff);
      slow_speed = ((ACC_W+1)'(base_speed) <<< QB) - acc_mag;
      slow_drive = trunc_sat(slow_speed);
      base_drive = $signed({1'b0, base_speed});
      if (!run_mode) begin
         positive_in = !steer_clamped[ACC_W-1] && (steer_clamped != '0);
         left_in     = trunc_sat(steer_ext);
         right_in    = trunc_sat(-steer_ext);
      end else begin
         positive_in = !acc_ff[ACC_W-1] && (acc_ff != '0);
         left_in     = acc_ff[ACC_W-1] ? slow_drive : base_drive;
         right_in    = acc_ff[ACC_W-1] ? base_drive : slow_drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
         es_ff <= '0;
      end else if (cmd.accept) begin
         hist_ff <= hist_in;
         es_ff   <= es_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff      <= pos_in;
         straight_ff <= straight_in;
      end
      if (cmd.mul_p || cmd.mul_d || cmd.mul_i) prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (cmd.out_load) begin
         left_ff         <= left_in;
         right_ff        <= right_in;
         straight_out_ff <= straight_ff;
         positive_ff     <= positive_in;
      end
   end

   assign left_drive     = left_ff;
   assign right_drive    = right_ff;
   assign straight       = straight_out_ff;
   assign steer_positive = positive_ff;

endmodule

// ===== rtl/line_follower_pd_steering_unit.sv =====
// Top level of the line follower PD steering unit: register file and handshake ports.
// Depends on lfpd_pkg, lfpd_ctrl and lfpd_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tdata position, tuser restart
//   rsp_      out        rsp_tvalid/rsp_tready  tdata left/right drive, tuser flags
//   csr_      in         APB psel/penable       gains, base speed, run mode
//
// An accepted item steps through MUL_P, MUL_D, MUL_I and ACC_I, its result is loaded in FINISH,
// and no new item is accepted until the unit is back in idle: one multiplier is shared
// by the proportional, derivative and integral products in turn.
// The result register frees the input side, so the next item is accepted in the cycle
// after the previous one has been moved into it. Reset clears history and integral at
// once and restores the register defaults. A stalled result holds the unit in its
// final step until the result register drains.
module line_follower_pd_steering_unit #(
   parameter int HISTORY_DEPTH  = lfpd_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int INTEGRAL_LIMIT = lfpd_pkg::INTEGRAL_LIMIT_DEFAULT,
   parameter int POSITION_BITS  = lfpd_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((POSITION_BITS+7)/8)*8-1:0] req_tdata,  // position
   input  logic                               req_tuser,  // restart
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,  // left_drive, right_drive
   output logic [1:0]                         rsp_tuser,  // straight, steer_positive
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lfpd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lfpd_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int DW = lfpd_pkg::DRIVE_BITS;

   logic [lfpd_pkg::GAIN_BITS-1:0]  gain_prop_ff, gain_deriv_ff, gain_integ_ff;
   logic [lfpd_pkg::SPEED_BITS-1:0] base_speed_ff;
   logic                            run_mode_ff;
   logic                            csr_write;
   lfpd_pkg::reg_index_type         csr_index;
   lfpd_pkg::cmd_type               cmd;
   logic signed [DW-1:0]            left_drive, right_drive;
   logic                            straight, steer_positive;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = lfpd_pkg::reg_index_type'(csr_paddr[lfpd_pkg::CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= lfpd_pkg::GAIN_PROP_RESET;
         gain_deriv_ff <= lfpd_pkg::GAIN_DERIV_RESET;
         gain_integ_ff <= lfpd_pkg::GAIN_INTEG_RESET;
         base_speed_ff <= lfpd_pkg::BASE_SPEED_RESET;
         run_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            lfpd_pkg::REG_GAIN_PROP:  gain_prop_ff  <= csr_pwdata[lfpd_pkg::GAIN_BITS-1:0];
            lfpd_pkg::REG_GAIN_DERIV: gain_deriv_ff <= csr_pwdata[lfpd_pkg::GAIN_BITS-1:0];
            lfpd_pkg::REG_GAIN_INTEG: gain_integ_ff <= csr_pwdata[lfpd_pkg::GAIN_BITS-1:0];
            lfpd_pkg::REG_BASE_SPEED: base_speed_ff <= csr_pwdata[lfpd_pkg::SPEED_BITS-1:0];
            lfpd_pkg::REG_RUN_MODE:   run_mode_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lfpd_pkg::REG_GAIN_PROP:  csr_prdata = lfpd_pkg::CSR_DATA_BITS'(gain_prop_ff);
         lfpd_pkg::REG_GAIN_DERIV: csr_prdata = lfpd_pkg::CSR_DATA_BITS'(gain_deriv_ff);
         lfpd_pkg::REG_GAIN_INTEG: csr_prdata = lfpd_pkg::CSR_DATA_BITS'(gain_integ_ff);
         lfpd_pkg::REG_BASE_SPEED: csr_prdata = lfpd_pkg::CSR_DATA_BITS'(base_speed_ff);
         lfpd_pkg::REG_RUN_MODE:   csr_prdata = lfpd_pkg::CSR_DATA_BITS'(run_mode_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   lfpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lfpd_datapath #(
      .HISTORY_DEPTH  (HISTORY_DEPTH),
      .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
      .POSITION_BITS  (POSITION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .gain_prop      (gain_prop_ff),
      .gain_deriv     (gain_deriv_ff),
      .gain_integ     (gain_integ_ff),
      .base_speed     (base_speed_ff),
      .run_mode       (run_mode_ff),
      .position       (req_tdata[POSITION_BITS-1:0]),
      .restart        (req_tuser),
      .left_drive     (left_drive),
      .right_drive    (right_drive),
      .straight       (straight),
      .steer_positive (steer_positive)
   );

   assign rsp_tdata = {6'b0, right_drive, left_drive};
   assign rsp_tuser = {steer_positive, straight};

endmodule

// ===== tb/sv/lfpd_steering_checker.sv =====
// Checker for the line follower PD steering unit: follows register writes, predicts
// each steering result from the accepted positions and compares it with the result stream.
// Depends on lfpd_pkg only.
module lfpd_steering_checker #(
   parameter int HISTORY_DEPTH  = lfpd_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int INTEGRAL_LIMIT = lfpd_pkg::INTEGRAL_LIMIT_DEFAULT,
   parameter int POSITION_BITS  = lfpd_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [((POSITION_BITS+7)/8)*8-1:0] req_tdata,  // position
   input  logic                               req_tuser,  // restart
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [23:0]                        rsp_tdata,  // left_drive, right_drive
   input  logic [1:0]                         rsp_tuser,  // straight, steer_positive
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lfpd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic                               csr_pready,
   output int                                 mismatch_count,
   output int                                 pending_results
);
   import lfpd_pkg::*;

   localparam longint Q_ONE = 64'sd1 << Q_BITS;

   typedef struct packed {
      logic [DRIVE_BITS-1:0] left;
      logic [DRIVE_BITS-1:0] right;
      logic                  straight;
      logic                  steer_positive;
   } steer_result_type;

   logic [GAIN_BITS-1:0]  kp, kd, ki;
   logic [SPEED_BITS-1:0] cruise;
   logic                  race_mode;
   int                    trail[HISTORY_DEPTH];
   int                    integ_sum;
   steer_result_type      expected_steering[$];
   steer_result_type      want, got;
   int                    fault_total = 0;
   int                    results_seen = 0;
   int                    position;
   logic [POSITION_BITS-1:0] raw_position;

   function automatic logic [DRIVE_BITS-1:0] to_drive(input longint q16);
      longint level;
      level = q16 / Q_ONE;
      if (level > DRIVE_MAX) level = DRIVE_MAX;
      if (level < -DRIVE_MAX) level = -DRIVE_MAX;
      return level[DRIVE_BITS-1:0];
   endfunction

   function automatic steer_result_type compute_steering(input int p, input bit restart);
      steer_result_type r;
      longint u, base, integ, limit;
      bit all_small;
      if (restart) begin
         foreach (trail[i]) trail[i] = 0;
         integ_sum = 0;
      end
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) trail[i] = trail[i-1];
      trail[0] = p;
      all_small = 1'b1;
      foreach (trail[i])
         if (trail[i] > STRAIGHT_BAND || trail[i] < -STRAIGHT_BAND) all_small = 1'b0;
      r.straight = all_small;
      if (!race_mode) begin
         if (p == 0) integ_sum = 0;
         if (integ_sum >= INTEGRAL_LIMIT) integ_sum = INTEGRAL_LIMIT;
         else if (integ_sum <= -INTEGRAL_LIMIT) integ_sum = -INTEGRAL_LIMIT;
         else integ_sum += p;
         integ = (longint'(ki) * integ_sum) / Q_ONE;
         u = longint'(kp) * p + longint'(kd) * (p - trail[TAP_TEST]) + integ * Q_ONE;
         limit = longint'(STEER_LIMIT) * Q_ONE;
         if (u > limit) u = limit;
         if (u < -limit) u = -limit;
         r.steer_positive = (u > 0);
         r.left = to_drive(u);
         r.right = to_drive(-u);
      end else begin
         base = longint'(cruise) * Q_ONE;
         u = longint'(kp) * p + longint'(kd) * (p - trail[TAP_RACE]);
         r.steer_positive = (u > 0);
         if (u >= 0) begin
            r.left = to_drive(base);
            r.right = to_drive(base - u);
         end else begin
            r.left = to_drive(base + u);
            r.right = to_drive(base);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp = GAIN_PROP_RESET;
         kd = GAIN_DERIV_RESET;
         ki = GAIN_INTEG_RESET;
         cruise = BASE_SPEED_RESET;
         race_mode = 1'b0;
         foreach (trail[i]) trail[i] = 0;
         integ_sum = 0;
         expected_steering.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_BITS-1:2])
               REG_GAIN_PROP:  kp = csr_pwdata[GAIN_BITS-1:0];
               REG_GAIN_DERIV: kd = csr_pwdata[GAIN_BITS-1:0];
               REG_GAIN_INTEG: ki = csr_pwdata[GAIN_BITS-1:0];
               REG_BASE_SPEED: cruise = csr_pwdata[SPEED_BITS-1:0];
               REG_RUN_MODE:   race_mode = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_steering.size() == 0) begin
               fault_total++;
               if (fault_total <= 10)
                  $display("result %0d arrived with nothing expected: tdata %h tuser %b",
                           results_seen, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_steering.pop_front();
               got.left = rsp_tdata[DRIVE_BITS-1:0];
               got.right = rsp_tdata[2*DRIVE_BITS-1:DRIVE_BITS];
               got.straight = rsp_tuser[0];
               got.steer_positive = rsp_tuser[1];
               if (got !== want || rsp_tdata[23:2*DRIVE_BITS] !== '0) begin
                  fault_total++;
                  if (fault_total <= 10) begin
                     $write("result %0d: left %0d/%0d right %0d/%0d ",
                            results_seen, $signed(want.left), $signed(got.left),
                            $signed(want.right), $signed(got.right));
                     $display("straight %b/%b positive %b/%b padding %h (expected/actual)",
                              want.straight, got.straight, want.steer_positive,
                              got.steer_positive, rsp_tdata[23:2*DRIVE_BITS]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            raw_position = req_tdata[POSITION_BITS-1:0];
            position = int'(raw_position);
            if (raw_position[POSITION_BITS-1]) position = position - (1 << POSITION_BITS);
            expected_steering.push_back(compute_steering(position, req_tuser));
         end
      end
      mismatch_count <= fault_total;
      pending_results <= expected_steering.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the line follower PD steering unit testbench: clock, reset, register writes,
// position stimulus and result back-pressure, plus the verdict.
// Depends on lfpd_pkg, line_follower_pd_steering_unit and lfpd_steering_checker.
module tb;
   import lfpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // position
   logic                     req_tuser;   // restart
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [23:0]              rsp_tdata;   // left_drive, right_drive
   logic [1:0]               rsp_tuser;   // straight, steer_positive
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int mismatch_count;
   int pending_results;
   int sender_idle_pct;
   int receiver_idle_pct;
   int stall_left;
   bit hold_request;

   line_follower_pd_steering_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   lfpd_steering_checker steering_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatch_count(mismatch_count), .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[line_follower_pd_steering_unit] ERROR");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic csr_write(input int index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(index << 2);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input int pos, input bit restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= 8'(pos);
      req_tuser <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         default: return $urandom_range(0, 1 << $urandom_range(8, 18));
      endcase
   endfunction

   task automatic load_settings(input int phase);
      logic [31:0] prop, deriv, integ, speed;
      if (phase == 1) begin
         prop = '1;
         deriv = '1;
         integ = '1;
         speed = '1;
      end else if (phase == 3) begin
         prop = '0;
         deriv = '0;
         integ = '0;
         speed = '0;
      end else begin
         prop = pick_gain();
         deriv = pick_gain();
         integ = pick_gain();
         speed = $urandom();
      end
      csr_write(REG_GAIN_PROP, prop);
      csr_write(REG_GAIN_DERIV, deriv);
      csr_write(REG_GAIN_INTEG, integ);
      csr_write(REG_BASE_SPEED, speed);
      csr_write(REG_RUN_MODE, ($urandom() & ~32'd1) | 32'(phase % 2));
      csr_write(REG_RUN_MODE + 1 + $urandom_range(2), $urandom());
   endtask

   task automatic run_random(input int count, input int hold_at);
      int burst_left, burst_kind, pos;
      bit burst_negative;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            burst_kind = $urandom_range(3);
            burst_negative = $urandom_range(1);
         end
         burst_left--;
         case (burst_kind)
            0: pos = int'($urandom_range(0, 20)) - 10;
            1: pos = burst_negative ? -int'($urandom_range(1, 128)) : $urandom_range(1, 127);
            2: pos = $urandom_range(0, 255);
            default: pos = ($urandom_range(2) == 0) ? 0 : int'($urandom_range(0, 2)) - 1;
         endcase
         if (n == hold_at) hold_request = 1'b1;
         send_item(pos, $urandom_range(39) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_request = 1'b0;
      sender_idle_pct = 21;
      receiver_idle_pct = 69;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default gains in test mode: clamping both ways, integral cleared by a zero
      // position, and the straight band edges just after a restart.
      send_item(0, 1'b1);
      send_item(127, 1'b0);
      send_item(-128, 1'b0);
      send_item(0, 1'b0);
      send_item(8, 1'b1);
      send_item(-8, 1'b0);
      send_item(9, 1'b0);
      send_item(-9, 1'b1);
      wait_drained();

      // Integral alone: it runs into its limit and stays there until a zero position.
      csr_write(REG_GAIN_PROP, 32'd0);
      csr_write(REG_GAIN_DERIV, 32'd0);
      csr_write(REG_GAIN_INTEG, 32'h0000_0100);
      send_item(127, 1'b1);
      repeat (8) send_item(127, 1'b0);
      repeat (3) send_item(-128, 1'b0);
      send_item(0, 1'b0);
      wait_drained();

      // Race mode with excess register bits and a write past the register list;
      // the drives saturate in both directions.
      csr_write(REG_GAIN_PROP, 32'hFFFF_FFFF);
      csr_write(REG_BASE_SPEED, 32'hABCD_EFFF);
      csr_write(REG_RUN_MODE, 32'hFFFF_FFFF);
      csr_write(REG_RUN_MODE + 1, 32'd0);
      send_item(127, 1'b0);
      send_item(-128, 1'b0);
      send_item(0, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            sender_idle_pct = 21;
            receiver_idle_pct = 69;
         end else if (phase < 6) begin
            sender_idle_pct = 69;
            receiver_idle_pct = 21;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         load_settings(phase);
         run_random(130, (phase == 0 || phase == 6) ? 40 : -1);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("[line_follower_pd_steering_unit] OK");
      end else begin
         $display("[line_follower_pd_steering_unit] ERROR");
      end
      $finish;
   end

endmodule
